### design/podl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PPS discipline loop package
// Shared widths, reset values, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package podl_pkg;

    // Window of accepted period errors.
    localparam int WINDOW_DEPTH = 10;
    localparam int ERR_W        = 21;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W        = ERR_W + FILL_W;

    // Fixed field and register widths.
    localparam int CAP_W     = 32;
    localparam int ERRX_W    = CAP_W + 1;
    localparam int LIMIT_W   = 20;
    localparam int GAIN_W    = 16;
    localparam int LEVEL_W   = 14;
    localparam int SKIP_W    = 2;
    localparam int FRAC_W    = 16;
    localparam int Q_FRAC    = 8;
    localparam int MEAN_W    = 29;
    localparam int MAG_W     = MEAN_W - 1;
    localparam int DIV_W     = SUM_W - 1 + Q_FRAC;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int MUL_CNT_W = $clog2(GAIN_W);
    localparam int PROD_W    = MAG_W + GAIN_W;
    localparam int STEP_W    = PROD_W - Q_FRAC;
    localparam int DRV_W     = 31;
    localparam int ACC_W     = STEP_W + 2;

    // Bus widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = CAP_W + MEAN_W + LEVEL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int APB_DATA_W  = 32;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = ADDR_W - 2;

    // Capture value that marks a missing timestamp.
    localparam logic [CAP_W-1:0] SENTINEL_CAPTURE = 32'hFFFF_FFFE;

    // Register reset values.
    localparam logic [CAP_W-1:0]   RST_TARGET_COUNT  = 32'd120000000;
    localparam logic [LIMIT_W-1:0] RST_OUTLIER_LIMIT = 20'd1000000;
    localparam logic [GAIN_W-1:0]  RST_GAIN_Q16      = 16'd6554;
    localparam logic [LEVEL_W-1:0] RST_START_LEVEL   = 14'd3846;
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL     = 14'd8192;
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL     = 14'd0;
    localparam logic [SKIP_W-1:0]  RST_SKIP_COUNT    = 2'd2;

    // Register indexes (byte address / 4).
    localparam logic [REG_IDX_W-1:0] REG_TARGET_COUNT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OUTLIER_LIMIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_Q16      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_LEVEL   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SKIP_COUNT    = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_ERROR,
        ST_GATE,
        ST_SUM,
        ST_DIVLOAD,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_CLAMP,
        ST_EMIT
    } podl_state_t;

endpackage
`default_nettype wire

### design/podl_sdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PPS discipline loop serial divider
// Restoring division, one quotient bit per cycle, of an unsigned dividend by
// the small fill count of the error window.
// ----------------------------------------------------------------------------
module podl_sdiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [podl_pkg::DIV_W-1:0]   dividend,
    input  logic [podl_pkg::FILL_W-1:0]  divisor,
    output logic                         busy,
    output logic [podl_pkg::DIV_W-1:0]   quotient
);
    import podl_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [FILL_W-1:0]    rem_reg, rem_next;
    logic [FILL_W-1:0]    dsr_reg, dsr_next;
    logic [FILL_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The remainder always stays below the divisor, so it fits FILL_W bits.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = FILL_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[FILL_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### design/podl_smul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PPS discipline loop serial multiplier
// Shift-and-add product of the mean error magnitude and the loop gain, one
// gain bit per cycle.
// ----------------------------------------------------------------------------
module podl_smul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [podl_pkg::MAG_W-1:0]   multiplicand,
    input  logic [podl_pkg::GAIN_W-1:0]  multiplier,
    output logic                         busy,
    output logic [podl_pkg::PROD_W-1:0]  product
);
    import podl_pkg::*;

    logic                 busy_reg, busy_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [MAG_W-1:0]     mcand_reg, mcand_next;
    logic [MAG_W:0]       part;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        part       = {1'b0, prod_reg[PROD_W-1:GAIN_W]}
                   + {1'b0, (prod_reg[0] ? mcand_reg : MAG_W'(0))};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            prod_next  = {MAG_W'(0), multiplier};
            mcand_next = multiplicand;
        end
        else if (busy_reg)
        begin
            // Upper half takes the partial sum while the gain bits shift out below.
            prod_next = {part, prod_reg[GAIN_W-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(GAIN_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign busy    = busy_reg;
    assign product = prod_reg;

endmodule
`default_nettype wire

### design/pps_oscillator_discipline_loop_core.sv
`default_nettype none
// A capture runs through the period, error and gate states, the window sum, the
// 32-step divide and 16-step multiply, then accumulate, clamp and emit; the next
// capture is taken only after that result is emitted; outliers end at the gate.
// Sentinel and seeding captures end in their transfer cycle with no result.
// Asynchronous reset loads the register defaults, clears window, counters and
// timestamp, and sets the drive accumulator to the start level.
// ----------------------------------------------------------------------------
// PPS oscillator discipline loop core
// Turns PPS timer captures into period errors, averages them over a ring
// window and steers a clamped proportional drive level for the oscillator.
// ----------------------------------------------------------------------------
module pps_oscillator_discipline_loop_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Capture stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [podl_pkg::IN_TDATA_W-1:0]   s_tdata,   // [31:0] capture_count
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] period_ticks, [60:32] mean_error_q8, [74:61] drive_level, [79:75] zero
    output logic [podl_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [podl_pkg::ADDR_W-1:0]       paddr,
    input  logic [podl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [podl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import podl_pkg::*;

    // Configuration registers.
    logic [CAP_W-1:0]   target_count_reg,  target_count_next;
    logic [LIMIT_W-1:0] outlier_limit_reg, outlier_limit_next;
    logic [GAIN_W-1:0]  gain_q16_reg,      gain_q16_next;
    logic [LEVEL_W-1:0] start_level_reg,   start_level_next;
    logic [LEVEL_W-1:0] max_level_reg,     max_level_next;
    logic [LEVEL_W-1:0] min_level_reg,     min_level_next;
    logic [SKIP_W-1:0]  skip_count_reg,    skip_count_next;

    // Loop state.
    podl_state_t        state_reg, state_next;
    logic [CAP_W-1:0]   last_capture_reg, last_capture_next;
    logic [SKIP_W-1:0]  seed_reg, seed_next;
    logic [ERR_W-1:0]   window_reg [WINDOW_DEPTH];
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]  filled_reg, filled_next;
    logic [DRV_W-1:0]   drive_reg, drive_next;

    // Per-item working registers.
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [CAP_W-1:0]   period_reg, period_next;
    logic [ERRX_W-1:0]  err_reg, err_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               neg_reg, neg_next;
    logic [MEAN_W-1:0]  mean_reg, mean_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    // Output holding register.
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CAP_W-1:0]   out_period_reg, out_period_next;
    logic [MEAN_W-1:0]  out_mean_reg, out_mean_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;

    // Datapath helpers.
    logic                 win_we;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [ERRX_W-1:0]    limit_pos;
    logic [ERRX_W-1:0]    limit_neg;
    logic [SUM_W-1:0]     sum_abs;
    logic [DIV_W-1:0]     div_dividend;
    logic                 div_start;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_quotient;
    logic                 mul_start;
    logic                 mul_busy;
    logic [PROD_W-1:0]    mul_product;
    logic [STEP_W-1:0]    step_mag;
    logic [ACC_W-1:0]     drive_ext;
    logic [ACC_W-1:0]     clamp_hi;
    logic [ACC_W-1:0]     clamp_lo;

    assign cfg_we  = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    // The outlier gate compares the signed error against plus and minus the limit.
    assign limit_pos = ERRX_W'(outlier_limit_reg);
    assign limit_neg = ERRX_W'(0) - limit_pos;

    // The divider works on magnitudes; the window sum is scaled to Q.8 on the way in.
    assign sum_abs      = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
    assign div_dividend = {sum_abs[SUM_W-2:0], Q_FRAC'(0)};

    // The step magnitude drops the eight extra fraction bits of the product,
    // which truncates toward zero because the sign is applied afterwards.
    assign step_mag  = mul_product[PROD_W-1:Q_FRAC];
    assign drive_ext = ACC_W'(drive_reg);
    assign clamp_hi  = ACC_W'({max_level_reg, FRAC_W'(0)});
    assign clamp_lo  = ACC_W'({min_level_reg, FRAC_W'(0)});

    podl_sdiv u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (filled_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    podl_smul u_smul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (div_quotient[MAG_W-1:0]),
        .multiplier   (gain_q16_reg),
        .busy         (mul_busy),
        .product      (mul_product)
    );

    // Sequencer: next state, datapath updates and configuration writes.
    always_comb
    begin
        state_next         = state_reg;
        target_count_next  = target_count_reg;
        outlier_limit_next = outlier_limit_reg;
        gain_q16_next      = gain_q16_reg;
        start_level_next   = start_level_reg;
        max_level_next     = max_level_reg;
        min_level_next     = min_level_reg;
        skip_count_next    = skip_count_reg;
        last_capture_next  = last_capture_reg;
        seed_next          = seed_reg;
        slot_next          = slot_reg;
        filled_next        = filled_reg;
        drive_next         = drive_reg;
        cap_next           = cap_reg;
        period_next        = period_reg;
        err_next           = err_reg;
        idx_next           = idx_reg;
        sum_next           = sum_reg;
        neg_next           = neg_reg;
        mean_next          = mean_reg;
        acc_next           = acc_reg;
        out_period_next    = out_period_reg;
        out_mean_next      = out_mean_reg;
        out_level_next     = out_level_reg;
        m_tvalid_next      = m_tvalid_reg;
        s_tready           = 1'b0;
        win_we             = 1'b0;
        div_start          = 1'b0;
        mul_start          = 1'b0;

        // A taken result frees the output register; a new one may refill it below.
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                // The sentinel capture is dropped without touching any state.
                // Seeding captures only set the timestamp.
                if (s_tvalid && (s_tdata != SENTINEL_CAPTURE))
                begin
                    if (seed_reg < skip_count_reg)
                    begin
                        last_capture_next = s_tdata;
                        seed_next         = seed_reg + 1'b1;
                    end
                    else
                    begin
                        cap_next   = s_tdata;
                        state_next = ST_PERIOD;
                    end
                end
            end
            ST_PERIOD:
            begin
                // The timer counts down, so the period is previous minus current.
                period_next       = last_capture_reg - cap_reg;
                last_capture_next = cap_reg;
                state_next        = ST_ERROR;
            end
            ST_ERROR:
            begin
                err_next   = {1'b0, period_reg} - {1'b0, target_count_reg};
                state_next = ST_GATE;
            end
            ST_GATE:
            begin
                if (($signed(err_reg) <= $signed(limit_pos))
                    && ($signed(err_reg) >= $signed(limit_neg)))
                begin
                    // An accepted error fits the window entry width.
                    win_we = 1'b1;
                    if (slot_reg == IDX_W'(WINDOW_DEPTH - 1))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                    if (filled_reg < FILL_W'(WINDOW_DEPTH))
                    begin
                        filled_next = filled_reg + 1'b1;
                    end
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                // Entries that were never written are still zero from reset,
                // so summing the whole window equals summing the filled part.
                sum_next = sum_reg + {{(SUM_W - ERR_W){window_reg[idx_reg][ERR_W-1]}},
                                      window_reg[idx_reg]};
                if (idx_reg == IDX_W'(WINDOW_DEPTH - 1))
                begin
                    state_next = ST_DIVLOAD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DIVLOAD:
            begin
                div_start  = 1'b1;
                neg_next   = sum_reg[SUM_W-1];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    mean_next  = neg_reg ? (MEAN_W'(0) - {1'b0, div_quotient[MAG_W-1:0]})
                                         : {1'b0, div_quotient[MAG_W-1:0]};
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (!mul_busy)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // A negative mean raises the drive, a positive one lowers it.
                if (neg_reg)
                begin
                    acc_next = drive_ext + ACC_W'(step_mag);
                end
                else
                begin
                    acc_next = drive_ext - ACC_W'(step_mag);
                end
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // The upper clamp is tested first, which also settles crossed limits.
                if ($signed(acc_reg) > $signed(clamp_hi))
                begin
                    drive_next = clamp_hi[DRV_W-1:0];
                end
                else if ($signed(acc_reg) < $signed(clamp_lo))
                begin
                    drive_next = clamp_lo[DRV_W-1:0];
                end
                else
                begin
                    drive_next = acc_reg[DRV_W-1:0];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Wait here only while an earlier result is still unclaimed.
                if (!m_tvalid_reg || m_tready)
                begin
                    out_period_next = period_reg;
                    out_mean_next   = mean_reg;
                    out_level_next  = drive_reg[FRAC_W+LEVEL_W-1:FRAC_W];
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The user must issue register writes only while the loop is idle; the block does not enforce it.
        if (cfg_we)
        begin
            case (reg_idx)
                REG_TARGET_COUNT:  target_count_next  = pwdata[CAP_W-1:0];
                REG_OUTLIER_LIMIT: outlier_limit_next = pwdata[LIMIT_W-1:0];
                REG_GAIN_Q16:      gain_q16_next      = pwdata[GAIN_W-1:0];
                REG_START_LEVEL:
                begin
                    // A new start level also restarts the drive accumulator.
                    start_level_next = pwdata[LEVEL_W-1:0];
                    drive_next       = DRV_W'({pwdata[LEVEL_W-1:0], FRAC_W'(0)});
                end
                REG_MAX_LEVEL:     max_level_next     = pwdata[LEVEL_W-1:0];
                REG_MIN_LEVEL:     min_level_next     = pwdata[LEVEL_W-1:0];
                REG_SKIP_COUNT:    skip_count_next    = pwdata[SKIP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            REG_TARGET_COUNT:  prdata = APB_DATA_W'(target_count_reg);
            REG_OUTLIER_LIMIT: prdata = APB_DATA_W'(outlier_limit_reg);
            REG_GAIN_Q16:      prdata = APB_DATA_W'(gain_q16_reg);
            REG_START_LEVEL:   prdata = APB_DATA_W'(start_level_reg);
            REG_MAX_LEVEL:     prdata = APB_DATA_W'(max_level_reg);
            REG_MIN_LEVEL:     prdata = APB_DATA_W'(min_level_reg);
            REG_SKIP_COUNT:    prdata = APB_DATA_W'(skip_count_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            target_count_reg  <= RST_TARGET_COUNT;
            outlier_limit_reg <= RST_OUTLIER_LIMIT;
            gain_q16_reg      <= RST_GAIN_Q16;
            start_level_reg   <= RST_START_LEVEL;
            max_level_reg     <= RST_MAX_LEVEL;
            min_level_reg     <= RST_MIN_LEVEL;
            skip_count_reg    <= RST_SKIP_COUNT;
            last_capture_reg  <= '0;
            seed_reg          <= '0;
            slot_reg          <= '0;
            filled_reg        <= '0;
            drive_reg         <= DRV_W'({RST_START_LEVEL, FRAC_W'(0)});
            m_tvalid_reg      <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            target_count_reg  <= target_count_next;
            outlier_limit_reg <= outlier_limit_next;
            gain_q16_reg      <= gain_q16_next;
            start_level_reg   <= start_level_next;
            max_level_reg     <= max_level_next;
            min_level_reg     <= min_level_next;
            skip_count_reg    <= skip_count_next;
            last_capture_reg  <= last_capture_next;
            seed_reg          <= seed_next;
            slot_reg          <= slot_next;
            filled_reg        <= filled_next;
            drive_reg         <= drive_next;
            m_tvalid_reg      <= m_tvalid_next;
            if (win_we)
            begin
                window_reg[slot_reg] <= err_reg[ERR_W-1:0];
            end
        end
    end

    // Working and output payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cap_reg        <= cap_next;
        period_reg     <= period_next;
        err_reg        <= err_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        neg_reg        <= neg_next;
        mean_reg       <= mean_next;
        acc_reg        <= acc_next;
        out_period_reg <= out_period_next;
        out_mean_reg   <= out_mean_next;
        out_level_reg  <= out_level_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {OUT_PAD_W'(0), out_level_reg, out_mean_reg, out_period_reg};

endmodule
`default_nettype wire
